@@ sv/frustum_box_cull_defines.svh @@
// ----------------------------------------------------------------------------
// frustum_box_cull_defines.svh
// Assertion macros for the frustum box cull block.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_DEFINES_SVH
`define FRUSTUM_BOX_CULL_DEFINES_SVH

`ifndef SYNTHESIS

`define FBC_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("frustum_box_cull: check failed");

`define FBC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("frustum_box_cull: check failed");

`else

`define FBC_ASSERT_NOW(label, clk, rst_n, pre, post)

`define FBC_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ sv/fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared constants for the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int DATA_W      = 32;
  localparam int MAT_DEPTH   = 16;
  localparam int MAT_IDX_W   = 4;
  localparam int MAT_ROWS    = 4;
  localparam int MAT_COLS    = 4;
  localparam int VERT_DIMS   = 3;

  localparam logic CMD_MATRIX = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  // input word layout
  localparam int IN_TDATA_W = 136;
  localparam int IDX_LSB    = 0;
  localparam int VAL_LSB    = 4;
  localparam int X_LSB      = 36;
  localparam int Y_LSB      = 68;
  localparam int Z_LSB      = 100;

  localparam int OUT_TDATA_W = 8;

endpackage

@@ sv/fbc_queue.sv @@
// ----------------------------------------------------------------------------
// fbc_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module fbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = (count_r != CNT_W'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

@@ sv/fbc_front.sv @@
// ----------------------------------------------------------------------------
// fbc_front
// Accepts words, applies matrix writes, and forms the four row dot products
// of each vertex over two pipeline stages.
// ----------------------------------------------------------------------------
module fbc_front #(
  parameter int FRACTION_BITS = 16,
  parameter int ROW_W         = 66
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [fbc_pkg::IN_TDATA_W-1:0] in_data,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [4*ROW_W-1:0]             out_rows,
  output logic                           out_last
);

  import fbc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int D_W    = DATA_W + FRACTION_BITS;

  logic signed [DATA_W-1:0] mat_r [MAT_DEPTH];

  logic                     accept;
  logic [MAT_IDX_W-1:0]     wr_idx;
  logic signed [DATA_W-1:0] wr_val;
  logic signed [DATA_W-1:0] vert [VERT_DIMS];

  logic                     s1_valid_r, s1_ready, s1_load;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] prod_nxt [MAT_ROWS][VERT_DIMS];
  logic signed [PROD_W-1:0] prod_r   [MAT_ROWS][VERT_DIMS];
  logic signed [DATA_W-1:0] dterm_r  [MAT_ROWS];

  logic                     s2_valid_r, s2_ready;
  logic                     s2_last_r;
  logic signed [D_W-1:0]    dsh      [MAT_ROWS];
  logic signed [ROW_W-1:0]  row_nxt  [MAT_ROWS];
  logic signed [ROW_W-1:0]  row_r    [MAT_ROWS];

  assign wr_idx  = in_data[IDX_LSB +: MAT_IDX_W];
  assign wr_val  = in_data[VAL_LSB +: DATA_W];
  assign vert[0] = in_data[X_LSB +: DATA_W];
  assign vert[1] = in_data[Y_LSB +: DATA_W];
  assign vert[2] = in_data[Z_LSB +: DATA_W];

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && in_ready;
  assign s1_load  = accept && (in_cmd == CMD_VERTEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_r[i] <= '0;
      end
    end else if (accept && (in_cmd == CMD_MATRIX)) begin
      mat_r[wr_idx] <= wr_val;
    end
  end

  // element (row r, column c) sits at r + 4*c
  always_comb begin
    for (int r = 0; r < MAT_ROWS; r++) begin
      for (int c = 0; c < VERT_DIMS; c++) begin
        prod_nxt[r][c] = mat_r[r + MAT_COLS * c] * vert[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAT_ROWS; r++) begin
      dsh[r]     = $signed({dterm_r[r], {FRACTION_BITS{1'b0}}});
      row_nxt[r] = ROW_W'(prod_r[r][0]) + ROW_W'(prod_r[r][1])
                 + ROW_W'(prod_r[r][2]) + ROW_W'(dsh[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= s1_load;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_load) begin
      s1_last_r <= in_last;
      for (int r = 0; r < MAT_ROWS; r++) begin
        dterm_r[r] <= mat_r[r + MAT_COLS * VERT_DIMS];
        for (int c = 0; c < VERT_DIMS; c++) begin
          prod_r[r][c] <= prod_nxt[r][c];
        end
      end
    end
    if (s2_ready && s1_valid_r) begin
      s2_last_r <= s1_last_r;
      for (int r = 0; r < MAT_ROWS; r++) begin
        row_r[r] <= row_nxt[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAT_ROWS; r++) begin
      out_rows[r*ROW_W +: ROW_W] = row_r[r];
    end
  end

  assign out_valid = s2_valid_r;
  assign out_last  = s2_last_r;

endmodule

@@ sv/fbc_back.sv @@
// ----------------------------------------------------------------------------
// fbc_back
// Forms the six plane distances, keeps the per-plane inside marks and
// registers the box verdict on the last vertex.
// ----------------------------------------------------------------------------
`include "frustum_box_cull_defines.svh"

module fbc_back #(
  parameter int ROW_W = 66
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [4*ROW_W-1:0]              q_rows,
  input  logic                            q_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_visible,
  output logic [fbc_pkg::PLANE_COUNT-1:0] out_outside
);

  import fbc_pkg::*;

  logic signed [ROW_W-1:0]  row3, rowk;
  logic signed [ROW_W:0]    pl_dist [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]   pos, hits;
  logic [PLANE_COUNT-1:0]   marks_r, marks_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     visible_r;
  logic [PLANE_COUNT-1:0]   outside_r;
  logic                     pop;

  assign row3 = q_rows[(MAT_ROWS-1)*ROW_W +: ROW_W];

  // plane 2k = row3 + rowk, plane 2k+1 = row3 - rowk
  always_comb begin
    rowk = '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      rowk = q_rows[(i >> 1)*ROW_W +: ROW_W];
      if ((i & 1) != 0) begin
        pl_dist[i] = (ROW_W+1)'(row3) - (ROW_W+1)'(rowk);
      end else begin
        pl_dist[i] = (ROW_W+1)'(row3) + (ROW_W+1)'(rowk);
      end
      pos[i] = !pl_dist[i][ROW_W] && (pl_dist[i] != '0);
    end
  end

  assign hits    = marks_r | pos;
  assign q_ready = !q_last || !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    marks_nxt     = marks_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (q_last) begin
        marks_nxt     = '0;
        out_valid_nxt = 1'b1;
      end else begin
        marks_nxt = hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_last) begin
      visible_r <= &hits;
      outside_r <= ~hits;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;
  assign out_outside = outside_r;

  `FBC_ASSERT_NOW(a_no_close_while_stalled, clk, rst_n,
                  out_valid_r && !out_ready, !(q_valid && q_ready && q_last))
  `FBC_ASSERT_NEXT(a_marks_clear_after_close, clk, rst_n,
                   q_valid && q_ready && q_last, marks_r == '0)
  `FBC_ASSERT_NEXT(a_result_only_from_close, clk, rst_n,
                   !(q_valid && q_ready && q_last) && !(out_valid_r && !out_ready),
                   !out_valid_r)

endmodule

@@ sv/frustum_box_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull
// Box test against the six clip planes of a view frustum.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_tready is high. A matrix write (tuser = 0)
// loads one column-major element and gives no result. A vertex (tuser = 1) runs
// through the front pipeline (twelve 32x32 products, then the four row sums),
// a two-entry queue, and the back part, which forms the six plane distances
// and updates the inside marks; the vertex with tlast set gives one result
// word through the product, row sum, queue and result registers. The product
// stage sets the throughput: one vertex per cycle, sustained, while the result
// side keeps up. No clearing pass after reset: the matrix resets to zero.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // matrix_index, matrix_value, vertex_x, vertex_y, vertex_z, zero pad
  input  logic [fbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                            in_tuser,
  // last_vertex
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // box_visible, outside_planes, zero pad
  output logic [fbc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import fbc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int D_W    = DATA_W + FRACTION_BITS;
  localparam int ROW_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;
  localparam int Q_W    = MAT_ROWS * ROW_W + 1;

  logic                        f_valid, f_ready, f_last;
  logic [MAT_ROWS*ROW_W-1:0]   f_rows;
  logic                        q_valid, q_ready;
  logic [Q_W-1:0]              q_data;
  logic                        b_visible;
  logic [PLANE_COUNT-1:0]      b_outside;

  fbc_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .ROW_W        (ROW_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_rows (f_rows),
    .out_last (f_last)
  );

  fbc_queue #(
    .WIDTH(Q_W),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_last, f_rows}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  fbc_back #(
    .ROW_W(ROW_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_rows     (q_data[MAT_ROWS*ROW_W-1:0]),
    .q_last     (q_data[Q_W-1]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_visible(b_visible),
    .out_outside(b_outside)
  );

  assign out_tdata = {{(OUT_TDATA_W - PLANE_COUNT - 1){1'b0}}, b_outside, b_visible};

endmodule

@@ sim/tb_frustum_box_cull.sv @@
// ----------------------------------------------------------------------------
// tb_frustum_box_cull
// Stream-level test of the frustum box cull block.
// ----------------------------------------------------------------------------
// Loads matrices one element per word and streams box corners through the
// block. An internal model rebuilds the six clip planes, evaluates the exact
// plane distances and predicts the verdict on each closing corner. Both
// sides idle at random, and the result side holds off once for a long stretch
// so that the input stalls. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int FRAC        = 16;
  localparam int ITEM_TARGET = 1350;
  localparam int HOLD_CYCLES = 300;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic        cmd;
    logic        last;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } cull_word_t;

  typedef struct packed {
    logic       visible;
    logic [5:0] outside;
  } verdict_t;

  class cull_tracker;
    logic signed [31:0] mat [16];
    logic [5:0]         marks;
    verdict_t           pending_verdicts [$];
    int                 errors;

    function new();
      foreach (mat[i]) mat[i] = '0;
      marks  = '0;
      errors = 0;
    endfunction

    function bit plane_inside(int p, logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] vz);
      logic signed [32:0] c [4];
      logic signed [32:0] a, b;
      logic signed [79:0] acc, cw, dw;
      int row;
      row = p / 2;
      for (int k = 0; k < 4; k++) begin
        a = mat[3 + 4 * k];
        b = mat[row + 4 * k];
        c[k] = (p % 2) ? a - b : a + b;
      end
      cw = c[0]; dw = vx; acc = cw * dw;
      cw = c[1]; dw = vy; acc = acc + cw * dw;
      cw = c[2]; dw = vz; acc = acc + cw * dw;
      dw = c[3];
      acc = acc + (dw <<< FRAC);
      return acc > 0;
    endfunction

    function void take_word(cull_word_t w);
      verdict_t v;
      if (w.cmd == CMD_MATRIX) begin
        mat[w.idx] = w.val;
        return;
      end
      for (int p = 0; p < PLANE_COUNT; p++)
        if (plane_inside(p, w.x, w.y, w.z)) marks[p] = 1'b1;
      if (w.last) begin
        v.visible = &marks;
        v.outside = ~marks;
        pending_verdicts.push_back(v);
        marks = '0;
      end
    endfunction

    function void check_verdict(logic [OUT_TDATA_W-1:0] d);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word, got %h", $time, d);
        errors++;
        return;
      end
      e = pending_verdicts.pop_front();
      if (d[0] !== e.visible) begin
        $display("%0t: box_visible expected %b got %b", $time, e.visible, d[0]);
        errors++;
      end
      if (d[6:1] !== e.outside) begin
        $display("%0t: outside_planes expected %b got %b", $time, e.outside, d[6:1]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  cull_tracker tracker = new();
  int  words_sent = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  bit  hold_req   = 1'b0;

  frustum_box_cull #(.FRACTION_BITS(FRAC)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return (32'($urandom_range(0, 8)) - 32'd4) << FRAC;
    endcase
  endfunction

  function automatic cull_word_t matrix_word(logic [3:0] idx, logic [31:0] val);
    cull_word_t w;
    w.cmd  = CMD_MATRIX;
    w.last = 1'($urandom);
    w.idx  = idx;
    w.val  = val;
    w.x    = $urandom;
    w.y    = $urandom;
    w.z    = $urandom;
    return w;
  endfunction

  function automatic cull_word_t vertex_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic last);
    cull_word_t w;
    w.cmd  = CMD_VERTEX;
    w.last = last;
    w.idx  = 4'($urandom);
    w.val  = $urandom;
    w.x    = x;
    w.y    = y;
    w.z    = z;
    return w;
  endfunction

  task automatic send_word(cull_word_t w);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, w.z, w.y, w.x, w.val, w.idx};
    in_tuser  <= w.cmd;
    in_tlast  <= w.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_word(w);
    words_sent++;
  endtask

  task automatic send_box(int n);
    for (int i = 0; i < n; i++)
      send_word(vertex_word(rand_q(), rand_q(), rand_q(), i == n - 1));
  endtask

  // result side
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = recv_quiet ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_verdict(out_tdata);
    end
  end

  initial begin
    bit pressed;
    pressed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero matrix: every distance is zero, so every plane is outside
    send_word(vertex_word(32'h0, 32'h0, 32'h0, 1'b1));
    // only w set: degenerate planes, the constant term decides
    send_word(matrix_word(4'd15, ONE));
    send_word(vertex_word(32'h0, 32'h0, 32'h0, 1'b1));
    send_word(matrix_word(4'd15, 32'h8000_0000));
    send_word(matrix_word(4'd0, 32'h7FFF_FFFF));
    send_word(matrix_word(4'd3, 32'h7FFF_FFFF));
    send_word(vertex_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_word(vertex_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0));
    send_word(vertex_word(32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1));
    // identity
    send_word(matrix_word(4'd0, ONE));
    send_word(matrix_word(4'd3, 32'h0));
    send_word(matrix_word(4'd5, ONE));
    send_word(matrix_word(4'd10, ONE));
    send_word(matrix_word(4'd15, ONE));
    send_word(vertex_word(32'h0, 32'h0, 32'h0, 1'b1));
    send_word(vertex_word(2 * ONE, 32'h0, 32'h0, 1'b1));
    // on the plane exactly
    send_word(vertex_word(ONE, 32'h0, 32'h0, 1'b1));
    send_word(vertex_word(2 * ONE, 32'h0, 32'h0, 1'b0));
    send_word(vertex_word(-2 * ONE, 32'h0, 32'h0, 1'b0));
    send_word(vertex_word(32'h0, 32'h0, 32'h0, 1'b1));

    while (words_sent < ITEM_TARGET) begin
      if (!pressed && words_sent > ITEM_TARGET / 2) begin
        pressed    = 1'b1;
        hold_req   = 1'b1;
        send_quiet = 1'b1;
        repeat (60) send_box(1);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = 0; i < 16; i++) send_word(matrix_word(4'(i), rand_q()));
        end
        8, 9: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
              send_word(matrix_word(4'($urandom), $urandom));
            else
              send_word(vertex_word($urandom, $urandom, $urandom, 1'($urandom)));
          end
        end
        default: begin
          repeat ($urandom_range(0, 2)) send_word(matrix_word(4'($urandom), rand_q()));
          send_box($urandom_range(0, 1) ? 8 : $urandom_range(1, 8));
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ frustum_box_cull.f @@
+incdir+sv
sv/fbc_pkg.sv
sv/fbc_queue.sv
sv/fbc_front.sv
sv/fbc_back.sv
sv/frustum_box_cull.sv
sim/tb_frustum_box_cull.sv
